// ===== rtl/core/mcal_pkg.sv =====
package mcal_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_START_PRICE  = 3'd0;
	localparam logic [2:0] REG_STRIKE_PRICE = 3'd1;
	localparam logic [2:0] REG_DRIFT_TERM   = 3'd2;
	localparam logic [2:0] REG_VOL_TERM     = 3'd3;
	localparam logic [2:0] REG_PATH_STEPS   = 3'd4;
	localparam logic [2:0] REG_INV_STEPS    = 3'd5;
	localparam logic [2:0] REG_PAYOFF_MODE  = 3'd6;

	// register reset values
	localparam logic [31:0] START_PRICE_RST  = 32'd6553600;
	localparam logic [31:0] STRIKE_PRICE_RST = 32'd7208960;
	localparam logic [12:0] PATH_STEPS_RST   = 13'd1;
	localparam logic [24:0] INV_STEPS_RST    = 25'd16777216;

	// saturation limits
	localparam logic [31:0] PRICE_MAX = 32'hFFFF_FFFF;
	localparam logic [43:0] SUM_MAX   = 44'hFFF_FFFF_FFFF;
	localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

	typedef struct packed {
		logic [31:0]        start_price;
		logic [31:0]        strike_price;
		logic signed [30:0] drift_term;
		logic [29:0]        vol_term;
		logic [12:0]        path_steps;
		logic [24:0]        inv_steps;
		logic               payoff_mode;
	} cfg_t;

endpackage

// ===== rtl/core/mcal_cfg.sv =====
module mcal_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output mcal_pkg::cfg_t    cfg
);

	mcal_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_price  <= mcal_pkg::START_PRICE_RST;
			cfg_q.strike_price <= mcal_pkg::STRIKE_PRICE_RST;
			cfg_q.drift_term   <= '0;
			cfg_q.vol_term     <= '0;
			cfg_q.path_steps   <= mcal_pkg::PATH_STEPS_RST;
			cfg_q.inv_steps    <= mcal_pkg::INV_STEPS_RST;
			cfg_q.payoff_mode  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mcal_pkg::REG_START_PRICE:  cfg_q.start_price  <= cfg_data;
				mcal_pkg::REG_STRIKE_PRICE: cfg_q.strike_price <= cfg_data;
				mcal_pkg::REG_DRIFT_TERM:   cfg_q.drift_term   <= $signed(cfg_data[30:0]);
				mcal_pkg::REG_VOL_TERM:     cfg_q.vol_term     <= cfg_data[29:0];
				mcal_pkg::REG_PATH_STEPS:   cfg_q.path_steps   <= cfg_data[12:0];
				mcal_pkg::REG_INV_STEPS:    cfg_q.inv_steps    <= cfg_data[24:0];
				mcal_pkg::REG_PAYOFF_MODE:  cfg_q.payoff_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/mcal_mul.sv =====
module mcal_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] prod_q
);

	// shared unsigned multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q <= 64'(op_a) * 64'(op_b);
	end

endmodule

// ===== rtl/core/mc_path_asian_lookback_payoff_top.sv =====
// Monte Carlo path engine: Euler steps of geometric Brownian motion with an
// Asian (average) or lookback (maximum) call payoff per finished path.
//
// Input channel (in_valid / in_stall): one item per step. command 0 applies
// normal_sample (Q4.12) as one price step; command 1 clears the totals and
// restarts the path, producing no result. Items are taken only while the
// sequencer is idle; in_stall is high while an item is being worked on.
// Output channel (out_valid / out_stall): one item per finished path with
// path_payoff, payoff_total and paths_done. The result sits in an output
// register; a stalled receiver holds it, and the next path may run meanwhile.
// A finishing path waits in its last state until the output register frees.
// Config channel (cfg_valid / cfg_ready): always ready, write while idle.
//
// Sequence: a step item runs through ST_MVZ to ST_ACC; a step that finishes a
// path goes on through ST_MAVH to ST_TOT; a clear item is done in ST_IDLE.
// The order is set by the single 32x32 multiplier, used in sequence for
// vol*sample, two price partial products and two partial products of the average.
// Reset: registers go to their listed reset values, path restarts from the
// reset start price, totals are zero, no result is pending.
module mc_path_asian_lookback_payoff_top #(
	parameter int MAX_STEPS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	// step items
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic signed [15:0] normal_sample,
	// path results
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        path_payoff,
	output logic [47:0]        payoff_total,
	output logic [23:0]        paths_done,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int SW = $clog2(MAX_STEPS + 1);
	localparam int LW = (SW > 13) ? SW : 13;

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MVZ   = 4'd1;  // vol * |sample|
	localparam logic [3:0] ST_FACT  = 4'd2;  // step factor, sign and magnitude
	localparam logic [3:0] ST_MLO   = 4'd3;  // price * factor low word
	localparam logic [3:0] ST_MHI   = 4'd4;  // price * factor high bits
	localparam logic [3:0] ST_DELTA = 4'd5;  // scaled price change
	localparam logic [3:0] ST_UPD   = 4'd6;  // new price, saturated
	localparam logic [3:0] ST_ACC   = 4'd7;  // sum, peak, step count
	localparam logic [3:0] ST_MAVH  = 4'd8;  // sum high part * inv_steps
	localparam logic [3:0] ST_MAVL  = 4'd9;  // sum low part * inv_steps
	localparam logic [3:0] ST_AVG   = 4'd10; // average or peak
	localparam logic [3:0] ST_PAY   = 4'd11; // minus strike, floored at zero
	localparam logic [3:0] ST_TOT   = 4'd12; // totals and result

	mcal_pkg::cfg_t cfg;

	logic [3:0]        state_q;
	logic signed [15:0] z_q;
	logic              fneg_q;
	logic [34:0]       mag_q;
	logic [63:0]       part_q;
	logic [37:0]       delta_q;
	logic [31:0]       value_q;
	logic [31:0]       payoff_q;

	logic [31:0]       price_q;
	logic [SW-1:0]     step_q;
	logic [43:0]       sum_q;
	logic [31:0]       peak_q;
	logic [47:0]       total_q;
	logic [23:0]       count_q;

	logic              out_valid_q;
	logic [31:0]       path_payoff_q;
	logic [47:0]       payoff_total_q;
	logic [23:0]       paths_done_q;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       prod_q;

	mcal_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcal_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	logic in_acc;
	logic slot_free;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// |sample| fits 16 bits unsigned, including the most negative code
	logic [15:0] zmag;
	assign zmag = z_q[15] ? 16'(~z_q + 16'sd1) : z_q;

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MVZ: begin
				mul_a = {2'b0, cfg.vol_term};
				mul_b = {16'b0, zmag};
			end
			ST_MLO: begin
				mul_a = price_q;
				mul_b = mag_q[31:0];
			end
			ST_MHI: begin
				mul_a = price_q;
				mul_b = {29'b0, mag_q[34:32]};
			end
			ST_MAVH: begin
				mul_a = {12'b0, sum_q[43:24]};
				mul_b = {7'b0, cfg.inv_steps};
			end
			ST_MAVL: begin
				mul_a = {8'b0, sum_q[23:0]};
				mul_b = {7'b0, cfg.inv_steps};
			end
			default: ;
		endcase
	end

	// step factor: floor(vol*z / 2^12) + drift, as sign and magnitude
	logic [46:0]        vz_mag;
	logic [46:0]        vz_rnd;
	logic [34:0]        vz_shr;
	logic signed [35:0] vz_s;
	logic signed [35:0] fct;
	logic [35:0]        fct_mag;
	always_comb begin
		vz_mag  = {1'b0, prod_q[45:0]};
		vz_rnd  = vz_mag + 47'd4095;
		vz_shr  = z_q[15] ? vz_rnd[46:12] : vz_mag[46:12];
		vz_s    = z_q[15] ? -$signed({1'b0, vz_shr}) : $signed({1'b0, vz_shr});
		fct     = vz_s + $signed({{5{cfg.drift_term[30]}}, cfg.drift_term});
		fct_mag = fct[35] ? 36'(-fct) : 36'(fct);
	end

	// price change: floor for growth, ceiling for decline
	logic [64:0] dec_rnd;
	logic [37:0] delta_d;
	always_comb begin
		dec_rnd = {1'b0, part_q} + 65'h3FFF_FFFF;
		if (fneg_q) begin
			delta_d = {5'b0, dec_rnd[62:30]};
		end else begin
			delta_d = {4'b0, part_q[63:30]} + {1'b0, prod_q[34:0], 2'b0};
		end
	end

	// new price with saturation at both ends
	logic [38:0] up_sum;
	logic [31:0] price_d;
	always_comb begin
		up_sum = {7'b0, price_q} + {1'b0, delta_q};
		if (!fneg_q) begin
			price_d = (up_sum[38:32] != '0) ? mcal_pkg::PRICE_MAX : up_sum[31:0];
		end else if (mag_q[34:30] != '0) begin
			price_d = '0;
		end else if (delta_q >= {6'b0, price_q}) begin
			price_d = '0;
		end else begin
			price_d = price_q - delta_q[31:0];
		end
	end

	// effective path length, clamped to [1, MAX_STEPS]
	logic [LW-1:0] len;
	logic [LW:0]   step_inc;
	logic          path_end;
	always_comb begin
		len = LW'(cfg.path_steps);
		if (len == '0)
			len = LW'(1);
		if (len > LW'(MAX_STEPS))
			len = LW'(MAX_STEPS);
		step_inc = (LW + 1)'(step_q) + (LW + 1)'(1);
		path_end = step_inc >= {1'b0, len};
	end

	logic [44:0] sum_add;
	logic [45:0] avg_sum;
	logic [32:0] pay_diff;
	logic [48:0] tot_add;
	assign sum_add  = {1'b0, sum_q} + {13'b0, price_q};
	assign avg_sum  = {1'b0, part_q[44:0]} + {21'b0, prod_q[48:24]};
	assign pay_diff = {1'b0, value_q} - {1'b0, cfg.strike_price};
	assign tot_add  = {1'b0, total_q} + {17'b0, payoff_q};

	logic [47:0] total_d;
	logic [23:0] count_d;
	assign total_d = tot_add[48] ? mcal_pkg::TOTAL_MAX : tot_add[47:0];
	assign count_d = (count_q == mcal_pkg::COUNT_MAX) ? count_q : count_q + 24'd1;

	// sequencer and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			price_q <= mcal_pkg::START_PRICE_RST;
			step_q  <= '0;
			sum_q   <= '0;
			peak_q  <= '0;
			total_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (command) begin
							total_q <= '0;
							count_q <= '0;
							price_q <= cfg.start_price;
							step_q  <= '0;
							sum_q   <= '0;
							peak_q  <= '0;
						end else begin
							state_q <= ST_MVZ;
						end
					end
				end
				ST_MVZ:   state_q <= ST_FACT;
				ST_FACT:  state_q <= ST_MLO;
				ST_MLO:   state_q <= ST_MHI;
				ST_MHI:   state_q <= ST_DELTA;
				ST_DELTA: state_q <= ST_UPD;
				ST_UPD: begin
					price_q <= price_d;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q  <= sum_add[44] ? mcal_pkg::SUM_MAX : sum_add[43:0];
					if (price_q > peak_q)
						peak_q <= price_q;
					step_q  <= SW'(step_inc);
					state_q <= path_end ? ST_MAVH : ST_IDLE;
				end
				ST_MAVH: state_q <= ST_MAVL;
				ST_MAVL: state_q <= ST_AVG;
				ST_AVG:  state_q <= ST_PAY;
				ST_PAY:  state_q <= ST_TOT;
				ST_TOT: begin
					if (slot_free) begin
						total_q <= total_d;
						count_q <= count_d;
						price_q <= cfg.start_price;
						step_q  <= '0;
						sum_q   <= '0;
						peak_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath scratch registers
	always_ff @(posedge clk) begin
		if (in_acc)
			z_q <= normal_sample;
		if (state_q == ST_FACT) begin
			fneg_q <= fct[35];
			mag_q  <= fct_mag[34:0];
		end
		// low price product, later the high average product
		if (state_q == ST_MHI || state_q == ST_MAVL)
			part_q <= prod_q;
		if (state_q == ST_DELTA)
			delta_q <= delta_d;
		if (state_q == ST_AVG) begin
			if (cfg.payoff_mode)
				value_q <= peak_q;
			else
				value_q <= (avg_sum[45:32] != '0) ? mcal_pkg::PRICE_MAX : avg_sum[31:0];
		end
		if (state_q == ST_PAY)
			payoff_q <= pay_diff[32] ? 32'd0 : pay_diff[31:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_TOT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TOT && slot_free) begin
			path_payoff_q  <= payoff_q;
			payoff_total_q <= total_d;
			paths_done_q   <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign path_payoff  = path_payoff_q;
	assign payoff_total = payoff_total_q;
	assign paths_done   = paths_done_q;

endmodule
